[rtl/core/m2q_pkg.sv]
// m2q_pkg: shared types and constants for the matrix to quaternion core
// no dependencies

package m2q_pkg;

    localparam int W     = 16;
    localparam int FRAC  = 14;

    // bits of each radicand, root and sum of squares
    localparam int RAD_W  = 19;
    localparam int SQI_W  = RAD_W + FRAC + 1;
    localparam int SQR_W  = (SQI_W + 1) / 2;
    localparam int SUMQ_W = 2 * W + 2;
    localparam int NRM_W  = SUMQ_W / 2;

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } t_branch;

endpackage

[rtl/core/m2q_sqrt_stage.sv]
// m2q_sqrt_stage: one registered step of a restoring integer square root
// depends on nothing but its parameters

module m2q_sqrt_stage #(
    parameter int VW = 34,
    parameter int RW = 17,
    parameter int BIT = 0,
    parameter int SW = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [VW-1:0] i_rem,
    input  logic [RW-1:0] i_root,
    input  logic [SW-1:0] i_side,
    output logic [VW-1:0] o_rem,
    output logic [RW-1:0] o_root,
    output logic [SW-1:0] o_side
);

    logic [VW+1:0] trial;
    logic [RW-1:0] cand;

    always_comb begin
        cand  = i_root | (RW'(1) << BIT);
        trial = (VW+2)'(cand) * (VW+2)'(cand);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= i_rem;
            o_root <= (trial <= (VW+2)'(i_rem)) ? cand : i_root;
            o_side <= i_side;
        end
    end

endmodule

[rtl/core/matrix_to_quaternion_core.sv]
// matrix_to_quaternion_core: shepperd rotation matrix to unit quaternion
// stages: 1 select, 17 root, 30 divide, 3 assemble/square/sum, 17 root, 30 divide,
//   1 output stage
// throughput: one item per cycle while the output is not held; the whole pipe advances on one enable
// stall: when the output is held, every stage holds, nothing is lost
// reset: i_rst_n synchronous active low, clears valid bits, threshold to 1
// depends on m2q_pkg and m2q_sqrt_stage

module matrix_to_quaternion_core #(
    parameter int QDIV_STEPS = 30
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // quat_w,quat_x,quat_y,quat_z
    output logic         m_axis_tuser,   // degenerate
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [15:0]  i_cfg_data      // near_zero_threshold
);

    localparam int W   = m2q_pkg::W;
    localparam int F   = m2q_pkg::FRAC;
    localparam int SQV = m2q_pkg::SQI_W;
    localparam int SQR = m2q_pkg::SQR_W;
    localparam int QV  = m2q_pkg::SUMQ_W;
    localparam int QR  = m2q_pkg::NRM_W;
    localparam int DEPTH = SQR + QDIV_STEPS + QR + QDIV_STEPS + 5;
    localparam logic signed [W-1:0] HI = W'((1 << (W-1)) - 1);
    localparam logic signed [W-1:0] LO = -HI - W'(1);

    // pipe moves when the output slot is free
    logic en;
    logic [DEPTH-1:0] r_vld;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    // threshold only changes with an empty pipe and no item offered
    assign o_cfg_ready = !(|r_vld) && !s_axis_tvalid;

    logic [15:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 16'd1;
            r_vld <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_thr <= i_cfg_data;
            if (en) r_vld <= {r_vld[DEPTH-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = r_vld[DEPTH-1];

    // stage 0: branch select, radicand, differences
    logic signed [W-1:0] m [9];
    always_comb for (int k = 0; k < 9; k++) m[k] = s_axis_tdata[k*W +: W];

    logic signed [W+2:0] tr, rad;
    logic signed [W+1:0] d0, d1, d2;
    m2q_pkg::t_branch br;
    always_comb begin
        tr = (W+3)'(m[0]) + (W+3)'(m[4]) + (W+3)'(m[8]);
        if (tr > 0) begin
            br = m2q_pkg::BR_W; rad = tr + (W+3)'(1 << F);
            d0 = (W+2)'(m[7]) - (W+2)'(m[5]); d1 = (W+2)'(m[2]) - (W+2)'(m[6]);
            d2 = (W+2)'(m[3]) - (W+2)'(m[1]);
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            br = m2q_pkg::BR_X;
            rad = (W+3)'(1 << F) + (W+3)'(m[0]) - (W+3)'(m[4]) - (W+3)'(m[8]);
            d0 = (W+2)'(m[7]) - (W+2)'(m[5]); d1 = (W+2)'(m[1]) + (W+2)'(m[3]);
            d2 = (W+2)'(m[2]) + (W+2)'(m[6]);
        end else if (m[4] > m[8]) begin
            br = m2q_pkg::BR_Y;
            rad = (W+3)'(1 << F) + (W+3)'(m[4]) - (W+3)'(m[0]) - (W+3)'(m[8]);
            d0 = (W+2)'(m[2]) - (W+2)'(m[6]); d1 = (W+2)'(m[1]) + (W+2)'(m[3]);
            d2 = (W+2)'(m[5]) + (W+2)'(m[7]);
        end else begin
            br = m2q_pkg::BR_Z;
            rad = (W+3)'(1 << F) + (W+3)'(m[8]) - (W+3)'(m[0]) - (W+3)'(m[4]);
            d0 = (W+2)'(m[3]) - (W+2)'(m[1]); d1 = (W+2)'(m[2]) + (W+2)'(m[6]);
            d2 = (W+2)'(m[5]) + (W+2)'(m[7]);
        end
    end

    // side data through the first root: {degen, branch, d0, d1, d2}
    localparam int SA = 3 + 3 * (W + 2);
    logic [SQV-1:0] r_rad;
    logic [SA-1:0]  r_sa;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad <= (rad > 0) ? SQV'(rad) << F : '0;
            r_sa  <= {rad <= 0, br, d0, d1, d2};
        end
    end

    // root of radicand, one bit per stage
    logic [SQV-1:0] sv [SQR+1];
    logic [SQR-1:0] sr [SQR+1];
    logic [SA-1:0]  ss [SQR+1];
    assign sv[0] = r_rad;
    assign sr[0] = '0;
    assign ss[0] = r_sa;
    for (genvar g = 0; g < SQR; g++) begin : g_sq1
        m2q_sqrt_stage #(.VW(SQV), .RW(SQR), .BIT(SQR-1-g), .SW(SA)) u_st (
            .i_clk(i_clk), .i_en(en), .i_rem(sv[g]), .i_root(sr[g]), .i_side(ss[g]),
            .o_rem(sv[g+1]), .o_root(sr[g+1]), .o_side(ss[g+1]));
    end

    // three restoring dividers of |d|*ONE by S, one quotient bit a stage
    localparam int NW = W + 2 + F;
    localparam int DW = SQR + 1;
    logic [NW-1:0] nr [3][QDIV_STEPS+1];
    logic [NW-1:0] qq [3][QDIV_STEPS+1];
    logic [2:0]    ng [QDIV_STEPS+1];
    logic [DW-1:0] dv [QDIV_STEPS+1];
    logic [SQR-1:0] rt [QDIV_STEPS+1];
    logic [2:0]    bh [QDIV_STEPS+1];
    logic signed [W+1:0] dd [3];
    assign dd[0] = ss[SQR][3*(W+2)-1 -: W+2];
    assign dd[1] = ss[SQR][2*(W+2)-1 -: W+2];
    assign dd[2] = ss[SQR][W+1:0];
    for (genvar c = 0; c < 3; c++) begin : g_d0
        logic [W+1:0] mag;
        assign mag = dd[c][W+1] ? (W+2)'(-dd[c]) : (W+2)'(dd[c]);
        // add half of S before dividing
        assign nr[c][0] = (NW'(mag) << F) + NW'(sr[SQR]);
        assign qq[c][0] = '0;
        assign ng[0][c] = dd[c][W+1];
    end
    assign dv[0] = {sr[SQR], 1'b0};
    assign rt[0] = sr[SQR];
    assign bh[0] = ss[SQR][SA-1 -: 3];
    for (genvar s = 0; s < QDIV_STEPS; s++) begin : g_dv1
        localparam int B = QDIV_STEPS - 1 - s;
        for (genvar c = 0; c < 3; c++) begin : g_c
            logic [NW+DW:0] t;
            assign t = (NW+DW+1)'(dv[s]) << B;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if ((NW+DW+1)'(nr[c][s]) >= t && B < NW) begin
                        nr[c][s+1] <= nr[c][s] - NW'(t);
                        qq[c][s+1] <= qq[c][s] | (NW'(1) << B);
                    end else begin
                        nr[c][s+1] <= nr[c][s];
                        qq[c][s+1] <= qq[c][s];
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                ng[s+1] <= ng[s]; dv[s+1] <= dv[s]; rt[s+1] <= rt[s]; bh[s+1] <= bh[s];
            end
        end
    end

    // assemble saturated components
    function automatic logic signed [W-1:0] satq(input logic [NW-1:0] q, input logic n);
        logic signed [W-1:0] v;
        v = (q > NW'(HI)) ? HI : W'(q);
        return n ? -v : v;
    endfunction

    logic signed [W-1:0] r_q [4];
    logic [2:0] r_bh;
    always_ff @(posedge i_clk) begin
        if (en) begin
            logic signed [W-1:0] big, a, b, c2;
            logic [SQR:0] bg;
            bg = ({1'b0, rt[QDIV_STEPS]} + 1'b1) >> 1;
            big = (bg > (SQR+1)'(HI)) ? HI : W'(bg);
            a  = satq(qq[0][QDIV_STEPS], ng[QDIV_STEPS][0]);
            b  = satq(qq[1][QDIV_STEPS], ng[QDIV_STEPS][1]);
            c2 = satq(qq[2][QDIV_STEPS], ng[QDIV_STEPS][2]);
            r_bh <= bh[QDIV_STEPS];
            if (bh[QDIV_STEPS][2]) begin
                r_q[0] <= ((1 << F) > HI) ? HI : W'(1 << F);
                r_q[1] <= '0; r_q[2] <= '0; r_q[3] <= '0;
            end else begin
                case (m2q_pkg::t_branch'(bh[QDIV_STEPS][1:0]))
                    m2q_pkg::BR_W: begin r_q[0]<=big; r_q[1]<=a; r_q[2]<=b; r_q[3]<=c2; end
                    m2q_pkg::BR_X: begin r_q[1]<=big; r_q[0]<=a; r_q[2]<=b; r_q[3]<=c2; end
                    m2q_pkg::BR_Y: begin r_q[2]<=big; r_q[0]<=a; r_q[1]<=b; r_q[3]<=c2; end
                    default:       begin r_q[3]<=big; r_q[0]<=a; r_q[1]<=b; r_q[2]<=c2; end
                endcase
            end
        end
    end

    // squares, registered, then summed
    logic [2*W-1:0] r_sq [4];
    logic signed [W-1:0] r_q2 [4];
    logic [2:0] r_bh2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_sq[k] <= (2*W)'(32'(r_q[k]) * 32'(r_q[k]));
                r_q2[k] <= r_q[k];
            end
            r_bh2 <= r_bh;
        end
    end

    // side: {skip, q0..q3}
    localparam int SB = 1 + 4 * W;
    logic [QV-1:0] r_sum;
    logic [SB-1:0] r_sb;
    always_ff @(posedge i_clk) begin
        if (en) begin
            logic [QV-1:0] t;
            t = QV'(r_sq[0]) + QV'(r_sq[1]) + QV'(r_sq[2]) + QV'(r_sq[3]);
            r_sum <= t;
            r_sb  <= {r_bh2[2] || ((t >> F) < QV'(r_thr)),
                      r_q2[0], r_q2[1], r_q2[2], r_q2[3]};
        end
    end

    logic [QV-1:0] qv [QR+1];
    logic [QR-1:0] qr [QR+1];
    logic [SB-1:0] qs [QR+1];
    assign qv[0] = r_sum;
    assign qr[0] = '0;
    assign qs[0] = r_sb;
    for (genvar g = 0; g < QR; g++) begin : g_sq2
        m2q_sqrt_stage #(.VW(QV), .RW(QR), .BIT(QR-1-g), .SW(SB)) u_st (
            .i_clk(i_clk), .i_en(en), .i_rem(qv[g]), .i_root(qr[g]), .i_side(qs[g]),
            .o_rem(qv[g+1]), .o_root(qr[g+1]), .o_side(qs[g+1]));
    end

    // four dividers of |q|*ONE by n
    localparam int NW2 = W + F;
    logic [NW2+QR:0] n2 [4][QDIV_STEPS+1];
    logic [NW2-1:0]  q2 [4][QDIV_STEPS+1];
    logic [3:0]      ng2 [QDIV_STEPS+1];
    logic [QR-1:0]   dn [QDIV_STEPS+1];
    logic [SB-1:0]   s2 [QDIV_STEPS+1];
    for (genvar c = 0; c < 4; c++) begin : g_n0
        logic signed [W-1:0] qc;
        logic [W-1:0] mg;
        assign qc = qs[QR][(4-c)*W-1 -: W];
        assign mg = qc[W-1] ? W'(-qc) : W'(qc);
        assign n2[c][0] = ((NW2+QR+1)'(mg) << F) + (NW2+QR+1)'(qr[QR] >> 1);
        assign q2[c][0] = '0;
        assign ng2[0][c] = qc[W-1];
    end
    assign dn[0] = qr[QR];
    assign s2[0] = qs[QR];
    for (genvar s = 0; s < QDIV_STEPS; s++) begin : g_dv2
        localparam int B = QDIV_STEPS - 1 - s;
        for (genvar c = 0; c < 4; c++) begin : g_c
            logic [NW2+QR+QDIV_STEPS:0] t;
            assign t = (NW2+QR+QDIV_STEPS+1)'(dn[s]) << B;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if ((NW2+QR+QDIV_STEPS+1)'(n2[c][s]) >= t && B < NW2) begin
                        n2[c][s+1] <= n2[c][s] - (NW2+QR+1)'(t);
                        q2[c][s+1] <= q2[c][s] | (NW2'(1) << B);
                    end else begin
                        n2[c][s+1] <= n2[c][s];
                        q2[c][s+1] <= q2[c][s];
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                ng2[s+1] <= ng2[s]; dn[s+1] <= dn[s]; s2[s+1] <= s2[s];
            end
        end
    end

    // final select and output register
    logic [4*W-1:0] r_out;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                logic [NW2-1:0] qm;
                logic signed [W-1:0] v;
                qm = q2[c][QDIV_STEPS];
                if (ng2[QDIV_STEPS][c]) v = (qm > NW2'(HI) + 1'b1) ? LO : W'(-qm);
                else                    v = (qm > NW2'(HI)) ? HI : W'(qm);
                if (s2[QDIV_STEPS][SB-1] || dn[QDIV_STEPS] == '0)
                    r_out[c*W +: W] <= s2[QDIV_STEPS][(4-c)*W-1 -: W];
                else
                    r_out[c*W +: W] <= v;
            end
        end
    end

    // degenerate flag rides a delay line as long as the pipe
    logic [DEPTH-1:0] r_dgl;
    always_ff @(posedge i_clk) begin
        if (en) r_dgl <= {r_dgl[DEPTH-2:0], (rad <= 0)};
    end

    // output ports
    assign m_axis_tdata = r_out;
    assign m_axis_tuser = r_dgl[DEPTH-1];

endmodule

[rtl/core/m2q_checker.sv]
// m2q_checker: port level checks of the matrix to quaternion core
// binds to matrix_to_quaternion_core

module m2q_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // output item holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed under stall");

    // input is open whenever output slot is free
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled with free output");

    // degenerate items carry the identity
    a_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:16] == 48'd0)
        else $error("degenerate item not identity");

endmodule

bind matrix_to_quaternion_core m2q_checker u_m2q_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser));
